@@ rtl/core/quaternion_to_euler_angles_core_assert.svh @@
// ---------------------------------------------------------------------------
// Quaternion to Euler angles assertion macros
// Shared property templates for the core's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_ASSERT_SVH

// same-cycle implication
`define Q2E_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define Q2E_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/q2e_pkg.sv @@
// ---------------------------------------------------------------------------
// Quaternion to Euler angles package
// Widths, constants, CORDIC angle table and shared helper functions.
// ---------------------------------------------------------------------------
package q2e_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ANGLE_WIDTH   = 16;

    localparam int QW        = 16;
    localparam int PW        = 32;
    localparam int CW        = 36;
    localparam int ZW        = 34;
    localparam int SH_W      = 5;
    localparam int ROOT_W    = 29;
    localparam int REM_W     = 32;
    localparam int SQ_CELLS  = 29;
    localparam int RAD_W     = 2 * SQ_CELLS;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DW    = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_THRESHOLD = 1'b1;

    localparam logic [CFG_DW-1:0] LOCK_THRESHOLD_RST = 15'd16382;

    localparam logic signed [CW-1:0] HALF_Q28 = CW'(1) <<< 27;
    localparam logic signed [CW-1:0] SP_RND   = CW'(1) <<< 13;
    localparam logic signed [CW-1:0] SP_MAX   = CW'(16384);
    localparam logic signed [CW-1:0] SP_MIN   = -CW'(16384);
    localparam logic [ROOT_W-1:0]    ONE_Q28  = ROOT_W'(1) << 28;
    localparam logic signed [ZW-1:0] PI_UNITS = ZW'(1) <<< 31;
    localparam logic signed [ZW-1:0] PITCH_MAX = ZW'(16384);
    localparam logic signed [ZW-1:0] PITCH_MIN = -ZW'(16384);

    localparam int AW_DOWN = (ANGLE_WIDTH > 16) ? ANGLE_WIDTH - 16 : 0;
    localparam int AW_HALF = (AW_DOWN > 0) ? AW_DOWN - 1 : 0;
    localparam int AW_UP   = (ANGLE_WIDTH < 16) ? 16 - ANGLE_WIDTH : 0;
    localparam logic signed [ZW-1:0] BAU_RND  = ZW'(1) <<< (31 - ANGLE_WIDTH);
    localparam logic signed [ZW-1:0] BAU_RND2 = ZW'(1) <<< AW_HALF;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } cordic_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } sqrt_t;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [SH_W-1:0] i);
        logic signed [ZW-1:0] a;
        case (i)
            5'd0:    a = ZW'(536870912);
            5'd1:    a = ZW'(316933406);
            5'd2:    a = ZW'(167458907);
            5'd3:    a = ZW'(85004756);
            5'd4:    a = ZW'(42667331);
            5'd5:    a = ZW'(21354465);
            5'd6:    a = ZW'(10679838);
            5'd7:    a = ZW'(5340245);
            5'd8:    a = ZW'(2670163);
            5'd9:    a = ZW'(1335087);
            5'd10:   a = ZW'(667544);
            5'd11:   a = ZW'(333772);
            5'd12:   a = ZW'(166886);
            5'd13:   a = ZW'(83443);
            5'd14:   a = ZW'(41722);
            5'd15:   a = ZW'(20861);
            5'd16:   a = ZW'(10430);
            5'd17:   a = ZW'(5215);
            5'd18:   a = ZW'(2608);
            5'd19:   a = ZW'(1304);
            5'd20:   a = ZW'(652);
            5'd21:   a = ZW'(326);
            5'd22:   a = ZW'(163);
            5'd23:   a = ZW'(81);
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic logic signed [CW-1:0] ext_prod(input logic signed [PW-1:0] a);
        return {{(CW-PW){a[PW-1]}}, a};
    endfunction

    function automatic logic signed [ZW-1:0] to_bau(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] q;
        q = (z + BAU_RND) >>> (32 - ANGLE_WIDTH);
        if (AW_DOWN > 0)
        begin
            q = (q + BAU_RND2) >>> AW_DOWN;
        end
        return q <<< AW_UP;
    endfunction

endpackage

@@ rtl/core/q2e_sqrt_cell.sv @@
// ---------------------------------------------------------------------------
// Square root cell
// One restoring digit step of an integer square root, registered.
// ---------------------------------------------------------------------------
module q2e_sqrt_cell (
    input  logic           clk,
    input  q2e_pkg::sqrt_t cin,
    output q2e_pkg::sqrt_t cout
);
    import q2e_pkg::*;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    sqrt_t            cout_next;
    sqrt_t            cout_reg;

    always_comb
    begin
        rem_sh = {cin.rem[REM_W-3:0], cin.rad[RAD_W-1 -: 2]};
        trial  = {{(REM_W-ROOT_W-1){1'b0}}, cin.root[ROOT_W-2:0], 2'b01};
        cout_next.rad = {cin.rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            cout_next.rem  = rem_sh - trial;
            cout_next.root = {cin.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            cout_next.rem  = rem_sh;
            cout_next.root = {cin.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        cout_reg <= cout_next;
    end

    assign cout = cout_reg;

endmodule

@@ rtl/core/q2e_cordic_cell.sv @@
// ---------------------------------------------------------------------------
// CORDIC cell
// One vectoring micro-rotation with its angle step, registered.
// ---------------------------------------------------------------------------
module q2e_cordic_cell (
    input  logic                        clk,
    input  logic [q2e_pkg::SH_W-1:0]    shift,
    input  q2e_pkg::cordic_t            cin,
    output q2e_pkg::cordic_t            cout
);
    import q2e_pkg::*;

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] step;
    cordic_t              cout_next;
    cordic_t              cout_reg;

    always_comb
    begin
        dx   = cin.y >>> shift;
        dy   = cin.x >>> shift;
        step = atan_entry(shift);
        cout_next.zero = cin.zero;
        if (!cin.y[CW-1])
        begin
            cout_next.x = cin.x + dx;
            cout_next.y = cin.y - dy;
            cout_next.z = cin.z + step;
        end
        else
        begin
            cout_next.x = cin.x - dx;
            cout_next.y = cin.y + dy;
            cout_next.z = cin.z - step;
        end
    end

    always_ff @(posedge clk)
    begin
        cout_reg <= cout_next;
    end

    assign cout = cout_reg;

endmodule

@@ rtl/core/q2e_cordic.sv @@
// ---------------------------------------------------------------------------
// CORDIC atan2 chain
// Quadrant pre-rotation followed by a row of vectoring cells.
// ---------------------------------------------------------------------------
module q2e_cordic (
    input  logic                           clk,
    input  logic signed [q2e_pkg::CW-1:0]  vec_y,
    input  logic signed [q2e_pkg::CW-1:0]  vec_x,
    output q2e_pkg::cordic_t               res
);
    import q2e_pkg::*;

    cordic_t pre_next;
    cordic_t pre_reg;
    cordic_t chain [0:CORDIC_STAGES];

    always_comb
    begin
        pre_next.zero = (vec_x == '0) && (vec_y == '0);
        if (vec_x[CW-1])
        begin
            pre_next.x = -vec_x;
            pre_next.y = -vec_y;
            pre_next.z = vec_y[CW-1] ? -PI_UNITS : PI_UNITS;
        end
        else
        begin
            pre_next.x = vec_x;
            pre_next.y = vec_y;
            pre_next.z = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        pre_reg <= pre_next;
    end

    assign chain[0] = pre_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        q2e_cordic_cell u_cell (
            .clk   (clk),
            .shift (SH_W'(i)),
            .cin   (chain[i]),
            .cout  (chain[i+1])
        );
    end

    assign res = chain[CORDIC_STAGES];

endmodule

@@ rtl/core/quaternion_to_euler_angles_core.sv @@
// ---------------------------------------------------------------------------
// Quaternion to Euler angles core
// Unit quaternion in Q1.14 to heading, pitch and bank in binary angle units.
// ---------------------------------------------------------------------------
// Fully pipelined: a quaternion may be started in every cycle, busy is always
// low, and each result appears with a one-cycle done strobe once its start
// has passed 4 product/sum stages, 29 square-root cells, one quadrant stage,
// 16 CORDIC cells and the output register. The result cannot be held off;
// capture it on the done cycle. Write the configuration registers only
// while no quaternion is in flight.
module quaternion_to_euler_angles_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    output logic                              done,
    input  logic                              cfg_write,
    input  logic [q2e_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [q2e_pkg::CFG_DW-1:0]        cfg_data,
    input  logic signed [q2e_pkg::QW-1:0]     quat_w,
    input  logic signed [q2e_pkg::QW-1:0]     quat_x,
    input  logic signed [q2e_pkg::QW-1:0]     quat_y,
    input  logic signed [q2e_pkg::QW-1:0]     quat_z,
    output logic signed [15:0]                heading_angle,
    output logic signed [15:0]                pitch_angle,
    output logic signed [15:0]                bank_angle,
    output logic                              gimbal_locked
);
    import q2e_pkg::*;

    `include "quaternion_to_euler_angles_core_assert.svh"

    localparam int LAT    = 4 + SQ_CELLS + 1 + CORDIC_STAGES + 1;
    localparam int ARG_D  = SQ_CELLS + 1;
    localparam int SP_D   = SQ_CELLS + CORDIC_STAGES + 2;

    logic              direction_reg;
    logic [CFG_DW-1:0] lock_threshold_reg;
    logic [LAT-1:0]    vld_reg;
    logic              accept;

    logic signed [PW-1:0] yz_reg, wx_reg, xz_reg, wy_reg, xx_reg;
    logic signed [PW-1:0] yy_reg, zz_reg, xy_reg, wz_reg;

    logic signed [CW-1:0] p_next, hu_y_next, hu_x_next, hl_y_next, hl_x_next;
    logic signed [CW-1:0] b_y_next, b_x_next;
    logic signed [CW-1:0] p_reg, hu_y_reg, hu_x_reg, hl_y_reg, hl_x_reg;
    logic signed [CW-1:0] b_y_reg, b_x_reg;

    logic signed [CW-1:0] sp_wide;
    logic signed [QW-1:0] sp_next;
    logic signed [QW-1:0] sp_reg;
    logic [QW-1:0]        sp_abs;
    logic                 locked_next;
    logic                 locked_reg;
    logic signed [CW-1:0] h_y_reg, h_x_reg, bk_y_reg, bk_x_reg;

    logic signed [2*QW-1:0] spsq_full;
    logic [ROOT_W-1:0]      spsq_reg;

    logic signed [CW-1:0] h_y_dly  [0:ARG_D-1];
    logic signed [CW-1:0] h_x_dly  [0:ARG_D-1];
    logic signed [CW-1:0] bk_y_dly [0:ARG_D-1];
    logic signed [CW-1:0] bk_x_dly [0:ARG_D-1];
    logic signed [QW-1:0] sp_dly   [0:SP_D-1];
    logic                 lk_dly   [0:SP_D-1];

    sqrt_t sq_chain [0:SQ_CELLS];

    logic signed [CW-1:0] pitch_y;
    logic signed [CW-1:0] pitch_x;
    cordic_t              pitch_res, head_res, bank_res;

    logic signed [ZW-1:0] sp_last;
    logic signed [ZW-1:0] pitch_val;
    logic signed [ZW-1:0] head_val;
    logic signed [ZW-1:0] bank_val;
    logic signed [15:0]   heading_next, pitch_next, bank_next;
    logic signed [15:0]   heading_reg, pitch_reg, bank_reg;
    logic                 locked_out_reg;

    assign accept = start && !busy;
    assign busy   = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg      <= 1'b0;
            lock_threshold_reg <= LOCK_THRESHOLD_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DIRECTION:      direction_reg      <= cfg_data[0];
                CFG_LOCK_THRESHOLD: lock_threshold_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], accept};
        end
    end

    assign done = vld_reg[LAT-1];

    // products
    always_ff @(posedge clk)
    begin
        yz_reg <= quat_y * quat_z;
        wx_reg <= quat_w * quat_x;
        xz_reg <= quat_x * quat_z;
        wy_reg <= quat_w * quat_y;
        xx_reg <= quat_x * quat_x;
        yy_reg <= quat_y * quat_y;
        zz_reg <= quat_z * quat_z;
        xy_reg <= quat_x * quat_y;
        wz_reg <= quat_w * quat_z;
    end

    // sums
    always_comb
    begin
        if (direction_reg)
        begin
            p_next    = ext_prod(yz_reg) + ext_prod(wx_reg);
            hu_y_next = ext_prod(xz_reg) - ext_prod(wy_reg);
            hl_y_next = -ext_prod(xz_reg) - ext_prod(wy_reg);
            b_y_next  = ext_prod(xy_reg) - ext_prod(wz_reg);
        end
        else
        begin
            p_next    = ext_prod(yz_reg) - ext_prod(wx_reg);
            hu_y_next = ext_prod(xz_reg) + ext_prod(wy_reg);
            hl_y_next = ext_prod(wy_reg) - ext_prod(xz_reg);
            b_y_next  = ext_prod(xy_reg) + ext_prod(wz_reg);
        end
        hu_x_next = HALF_Q28 - ext_prod(xx_reg) - ext_prod(yy_reg);
        hl_x_next = HALF_Q28 - ext_prod(yy_reg) - ext_prod(zz_reg);
        b_x_next  = HALF_Q28 - ext_prod(xx_reg) - ext_prod(zz_reg);
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        hu_y_reg <= hu_y_next;
        hu_x_reg <= hu_x_next;
        hl_y_reg <= hl_y_next;
        hl_x_reg <= hl_x_next;
        b_y_reg  <= b_y_next;
        b_x_reg  <= b_x_next;
    end

    // pitch sine, lock test, heading formula select
    always_comb
    begin
        sp_wide = (SP_RND - (p_reg <<< 1)) >>> 14;
        if (sp_wide > SP_MAX)
        begin
            sp_next = QW'(SP_MAX);
        end
        else if (sp_wide < SP_MIN)
        begin
            sp_next = QW'(SP_MIN);
        end
        else
        begin
            sp_next = sp_wide[QW-1:0];
        end
        sp_abs      = sp_next[QW-1] ? -sp_next : sp_next;
        locked_next = sp_abs[CFG_DW-1:0] > lock_threshold_reg;
    end

    always_ff @(posedge clk)
    begin
        sp_reg     <= sp_next;
        locked_reg <= locked_next;
        h_y_reg    <= locked_next ? hl_y_reg : hu_y_reg;
        h_x_reg    <= locked_next ? hl_x_reg : hu_x_reg;
        bk_y_reg   <= b_y_reg;
        bk_x_reg   <= b_x_reg;
    end

    assign spsq_full = sp_reg * sp_reg;

    always_ff @(posedge clk)
    begin
        spsq_reg <= spsq_full[ROOT_W-1:0];
    end

    // align side data with the square root and CORDIC rows
    always_ff @(posedge clk)
    begin
        h_y_dly[0]  <= h_y_reg;
        h_x_dly[0]  <= h_x_reg;
        bk_y_dly[0] <= bk_y_reg;
        bk_x_dly[0] <= bk_x_reg;
        for (int i = 1; i < ARG_D; i++)
        begin
            h_y_dly[i]  <= h_y_dly[i-1];
            h_x_dly[i]  <= h_x_dly[i-1];
            bk_y_dly[i] <= bk_y_dly[i-1];
            bk_x_dly[i] <= bk_x_dly[i-1];
        end
        sp_dly[0] <= sp_reg;
        lk_dly[0] <= locked_reg;
        for (int i = 1; i < SP_D; i++)
        begin
            sp_dly[i] <= sp_dly[i-1];
            lk_dly[i] <= lk_dly[i-1];
        end
    end

    assign sq_chain[0].rem  = '0;
    assign sq_chain[0].root = '0;
    assign sq_chain[0].rad  = {1'b0, ONE_Q28 - spsq_reg, 28'd0};

    for (genvar i = 0; i < SQ_CELLS; i++)
    begin : g_sqrt
        q2e_sqrt_cell u_sqrt (
            .clk  (clk),
            .cin  (sq_chain[i]),
            .cout (sq_chain[i+1])
        );
    end

    assign pitch_y = {{(CW-QW){sp_dly[ARG_D-1][QW-1]}}, sp_dly[ARG_D-1]} <<< 14;
    assign pitch_x = {{(CW-ROOT_W){1'b0}}, sq_chain[SQ_CELLS].root};

    q2e_cordic u_pitch (
        .clk   (clk),
        .vec_y (pitch_y),
        .vec_x (pitch_x),
        .res   (pitch_res)
    );

    q2e_cordic u_head (
        .clk   (clk),
        .vec_y (h_y_dly[ARG_D-1]),
        .vec_x (h_x_dly[ARG_D-1]),
        .res   (head_res)
    );

    q2e_cordic u_bank (
        .clk   (clk),
        .vec_y (bk_y_dly[ARG_D-1]),
        .vec_x (bk_x_dly[ARG_D-1]),
        .res   (bank_res)
    );

    // angle scaling and lock override
    always_comb
    begin
        sp_last  = {{(ZW-QW){sp_dly[SP_D-1][QW-1]}}, sp_dly[SP_D-1]};
        head_val = head_res.zero ? '0 : to_bau(head_res.z);
        bank_val = bank_res.zero ? '0 : to_bau(bank_res.z);
        if (lk_dly[SP_D-1])
        begin
            pitch_val = to_bau(sp_last <<< 16);
            bank_val  = '0;
        end
        else
        begin
            pitch_val = pitch_res.zero ? '0 : to_bau(pitch_res.z);
        end
        if (pitch_val > PITCH_MAX)
        begin
            pitch_val = PITCH_MAX;
        end
        else if (pitch_val < PITCH_MIN)
        begin
            pitch_val = PITCH_MIN;
        end
        heading_next = head_val[15:0];
        pitch_next   = pitch_val[15:0];
        bank_next    = bank_val[15:0];
    end

    always_ff @(posedge clk)
    begin
        heading_reg    <= heading_next;
        pitch_reg      <= pitch_next;
        bank_reg       <= bank_next;
        locked_out_reg <= lk_dly[SP_D-1];
    end

    assign heading_angle = heading_reg;
    assign pitch_angle   = pitch_reg;
    assign bank_angle    = bank_reg;
    assign gimbal_locked = locked_out_reg;

    `Q2E_ASSERT_IMPLY(a_done_tracks_start, done, $past(start, LAT), "done without start")
    `Q2E_ASSERT_IMPLY(a_lock_zero_bank, done && gimbal_locked, bank_angle == 16'sd0, "bank not zero under lock")
    `Q2E_ASSERT_IMPLY(a_pitch_range, done, (pitch_angle <= 16'sd16384) && (pitch_angle >= -16'sd16384), "pitch out of range")
    `Q2E_ASSERT_NEXT(a_start_to_pipe, accept, vld_reg[0], "start not tracked")

endmodule
